@@ sv/osod_pkg.sv @@
// Shared types and constants for the occupancy sensor off-delay block.
package osod_pkg;

	// Number of sensor channels and field widths.
	localparam int CHANNELS = 8;
	localparam int REQ_W    = 2;
	localparam int CHAN_W   = 3;
	localparam int KIND_W   = 2;
	localparam int NODE_W   = 16;
	localparam int ADDR_W   = 16;
	localparam int TICK_W   = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// Request codes.
	localparam logic [REQ_W-1:0] REQ_SAMPLE = 2'd0;
	localparam logic [REQ_W-1:0] REQ_TICK   = 2'd1;
	localparam logic [REQ_W-1:0] REQ_POLL   = 2'd2;

	// Event kinds.
	localparam logic [KIND_W-1:0] EV_ON     = 2'd0;
	localparam logic [KIND_W-1:0] EV_OFF    = 2'd1;
	localparam logic [KIND_W-1:0] EV_SOD_ON = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_NODE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BASE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TICKS = 2'd2;

	// Reset values of the configuration registers.
	localparam logic [NODE_W-1:0] NODE_RST  = 16'd0;
	localparam logic [ADDR_W-1:0] BASE_RST  = 16'd9;
	localparam logic [TICK_W-1:0] TICKS_RST = 8'd40;

	// One input word as held in the input stage.
	typedef struct packed {
		logic [REQ_W-1:0]  req_type;
		logic [CHAN_W-1:0] channel;
		logic              level;
		logic              start_of_day;
		logic              queue_ready;
	} item_t;

	// State of the addressed channel.
	typedef struct packed {
		logic              last;
		logic              pend;
		logic [TICK_W-1:0] timer;
	} chan_sel_t;

	// State update for the channel bank.
	typedef struct packed {
		logic tick;
		logic wr_last;
		logic last_val;
		logic ld_timer;
		logic wr_pend;
		logic pend_val;
	} chan_upd_t;

endpackage

@@ sv/osod_ifs.sv @@
// Valid/ready channel interfaces for input and result words.
interface osod_in_if;
	logic                        valid;
	logic                        ready;
	logic [osod_pkg::REQ_W-1:0]  req_type;
	logic [osod_pkg::CHAN_W-1:0] channel;
	logic                        level;
	logic                        start_of_day;
	logic                        queue_ready;

	modport source (output valid, req_type, channel, level, start_of_day, queue_ready,
		input ready);
	modport sink (input valid, req_type, channel, level, start_of_day, queue_ready,
		output ready);
endinterface

interface osod_out_if;
	logic                        valid;
	logic                        ready;
	logic [osod_pkg::KIND_W-1:0] event_kind;
	logic [osod_pkg::NODE_W-1:0] event_node;
	logic [osod_pkg::ADDR_W-1:0] event_address;

	modport source (output valid, event_kind, event_node, event_address, input ready);
	modport sink (input valid, event_kind, event_node, event_address, output ready);
endinterface

@@ sv/osod_decide.sv @@
// Decision logic: turns the staged word and the addressed channel state into an event and updates.
module osod_decide (
	input  osod_pkg::item_t     item,
	input  osod_pkg::chan_sel_t sel,
	output logic                emit,
	output logic [osod_pkg::KIND_W-1:0] kind,
	output osod_pkg::chan_upd_t upd
);
	import osod_pkg::*;

	logic in_range;
	logic due;

	assign in_range = 32'(item.channel) < CHANNELS;

	// Work out what the word does to the addressed channel.
	always_comb begin
		upd  = '0;
		due  = 1'b0;
		emit = 1'b0;
		kind = EV_ON;
		case (item.req_type)
			REQ_TICK: begin
				upd.tick = 1'b1;
			end
			REQ_POLL: begin
				if (in_range && sel.pend && sel.timer == '0) begin
					upd.wr_pend  = 1'b1;
					upd.pend_val = 1'b0;
					emit         = item.queue_ready;
					kind         = EV_OFF;
				end
			end
			REQ_SAMPLE: begin
				if (in_range) begin
					if (item.start_of_day) begin
						upd.wr_last = 1'b1;
						due         = item.level;
						kind        = EV_SOD_ON;
					end else if (item.level != sel.last) begin
						upd.wr_last = 1'b1;
						if (!item.level) begin
							upd.ld_timer = 1'b1;
							upd.wr_pend  = 1'b1;
							upd.pend_val = 1'b1;
						end else if (sel.pend) begin
							// Back to occupied during the delay: cancel silently.
							upd.ld_timer = 1'b1;
							upd.wr_pend  = 1'b1;
							upd.pend_val = 1'b0;
						end else begin
							due  = 1'b1;
							kind = EV_ON;
						end
					end
				end
				// A blocked event leaves the level inverted so the change is seen again.
				upd.last_val = (due && !item.queue_ready) ? ~item.level : item.level;
				emit         = due && item.queue_ready;
			end
			default: begin
				upd = '0;
			end
		endcase
	end

endmodule

@@ sv/osod_bank.sv @@
// Per-channel state registers: last level, release timer and pending flag.
module osod_bank (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        go,
	input  logic [osod_pkg::CHAN_W-1:0] channel,
	input  logic [osod_pkg::TICK_W-1:0] release_ticks,
	input  osod_pkg::chan_upd_t         upd,
	output osod_pkg::chan_sel_t         sel
);
	import osod_pkg::*;

	logic              last_q  [CHANNELS];
	logic              pend_q  [CHANNELS];
	logic [TICK_W-1:0] timer_q [CHANNELS];

	// Read out the addressed channel.
	always_comb begin
		sel = '0;
		for (int i = 0; i < CHANNELS; i++) begin
			if (32'(channel) == i) begin
				sel.last  = last_q[i];
				sel.pend  = pend_q[i];
				sel.timer = timer_q[i];
			end
		end
	end

	// Update each channel from the broadcast tick or its own write.
	for (genvar g = 0; g < CHANNELS; g++) begin : g_chan
		logic hit;
		assign hit = go && (32'(channel) == g);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				last_q[g]  <= 1'b0;
				pend_q[g]  <= 1'b0;
				timer_q[g] <= '0;
			end else begin
				if (go && upd.tick && pend_q[g] && timer_q[g] != '0) begin
					timer_q[g] <= timer_q[g] - 1'b1;
				end
				if (hit && upd.ld_timer) begin
					timer_q[g] <= release_ticks;
				end
				if (hit && upd.wr_pend) begin
					pend_q[g] <= upd.pend_val;
				end
				if (hit && upd.wr_last) begin
					last_q[g] <= upd.last_val;
				end
			end
		end
	end

endmodule

@@ sv/osod_out_stage.sv @@
// Result register that holds one event word until the sink takes it.
module osod_out_stage (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	input  logic [osod_pkg::KIND_W-1:0] kind,
	input  logic [osod_pkg::NODE_W-1:0] node,
	input  logic [osod_pkg::ADDR_W-1:0] addr,
	output logic                        free,
	osod_out_if.source                  out_ch
);
	import osod_pkg::*;

	logic              valid_q;
	logic [KIND_W-1:0] kind_q;
	logic [NODE_W-1:0] node_q;
	logic [ADDR_W-1:0] addr_q;

	assign free = !valid_q || out_ch.ready;

	// Valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (push) begin
			valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			valid_q <= 1'b0;
		end
	end

	// Payload.
	always_ff @(posedge clk) begin
		if (push) begin
			kind_q <= kind;
			node_q <= node;
			addr_q <= addr;
		end
	end

	assign out_ch.valid         = valid_q;
	assign out_ch.event_kind    = kind_q;
	assign out_ch.event_node    = node_q;
	assign out_ch.event_address = addr_q;

endmodule

@@ sv/occupancy_sensor_off_delay.sv @@
// Occupancy sensor off-delay block: one word per cycle, a registered input stage feeding the
// channel update and a result register. A word is taken in every cycle unless the result
// register is full, not being taken, and the staged word would produce an event; its event,
// if any, enters the result register as the staged word moves on, held up only while the
// result register is blocked. The input stage and the result register are the only stages;
// channel state is updated in the same cycle the staged word moves on, so back-to-back words
// see each other's effects. The user must write configuration through the plain write port
// only while no word is in flight; the block itself does not enforce this.
module occupancy_sensor_off_delay (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [osod_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [osod_pkg::CFG_DATA_W-1:0] cfg_wdata,
	osod_in_if.sink                         in_ch,
	osod_out_if.source                      out_ch
);
	import osod_pkg::*;

	logic [NODE_W-1:0] node_q;
	logic [ADDR_W-1:0] base_q;
	logic [TICK_W-1:0] ticks_q;

	logic      valid_s1;
	item_t     item_s1;
	chan_sel_t sel;
	chan_upd_t upd;
	logic      emit;
	logic [KIND_W-1:0] kind;
	logic      out_free;
	logic      adv;
	logic      push;
	logic [ADDR_W-1:0] addr;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_q  <= NODE_RST;
			base_q  <= BASE_RST;
			ticks_q <= TICKS_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_NODE:  node_q  <= cfg_wdata;
				CFG_BASE:  base_q  <= cfg_wdata;
				CFG_TICKS: ticks_q <= cfg_wdata[TICK_W-1:0];
				default:   node_q  <= node_q;
			endcase
		end
	end

	// The staged word moves on unless it has an event and the result register is blocked.
	assign adv         = valid_s1 && (out_free || !emit);
	assign push        = adv && emit;
	assign in_ch.ready = !valid_s1 || adv;

	// Input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			item_s1.req_type     <= in_ch.req_type;
			item_s1.channel      <= in_ch.channel;
			item_s1.level        <= in_ch.level;
			item_s1.start_of_day <= in_ch.start_of_day;
			item_s1.queue_ready  <= in_ch.queue_ready;
		end
	end

	osod_bank u_bank (
		.clk           (clk),
		.arst_n        (arst_n),
		.go            (adv),
		.channel       (item_s1.channel),
		.release_ticks (ticks_q),
		.upd           (upd),
		.sel           (sel)
	);

	osod_decide u_decide (
		.item (item_s1),
		.sel  (sel),
		.emit (emit),
		.kind (kind),
		.upd  (upd)
	);

	// Event address wraps at 16 bits.
	assign addr = base_q + ADDR_W'(item_s1.channel);

	osod_out_stage u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.kind   (kind),
		.node   (node_q),
		.addr   (addr),
		.free   (out_free),
		.out_ch (out_ch)
	);

`ifndef SYNTHESIS
	// A staged word that cannot move on is still there next cycle.
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1)
		else $error("staged word lost while stalled");

	// Input is refused only while a staged word is blocked.
	a_ready_low: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ch.ready |-> valid_s1 && emit && !out_free)
		else $error("input refused without a blocked event");

	// No event is written over a result that has not been taken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !out_ch.valid || out_ch.ready)
		else $error("result register overwritten");

	// A sensor-off event only comes from a pending channel with an expired timer.
	a_off_source: assert property (@(posedge clk) disable iff (!arst_n)
		push && kind == EV_OFF |-> sel.pend && sel.timer == '0)
		else $error("sensor-off without expired release delay");
`endif

endmodule

@@ test/tb.sv @@
// Self-checking testbench for the occupancy sensor off-delay block with a predicting scoreboard.
`timescale 1ns / 1ps

module tb;
	import osod_pkg::*;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int LONG_HOLD      = 400;
	localparam int DRAIN_CYCLES   = 6;
	localparam int PHASE_ITEMS    = 270;
	localparam int FIRST_ITEMS    = 200;

	// One event word as seen on the result channel.
	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [NODE_W-1:0] node;
		logic [ADDR_W-1:0] addr;
	} sensor_event_t;

	// Tracks channel state, predicts events and checks the result words.
	class sensor_event_scoreboard;
		logic [NODE_W-1:0] node_num;
		logic [ADDR_W-1:0] addr_base;
		logic [TICK_W-1:0] rel_ticks;
		logic              last_level [CHANNELS];
		logic [TICK_W-1:0] rel_timer [CHANNELS];
		logic              rel_pending [CHANNELS];
		sensor_event_t     due_events [$];
		int                errors;

		function new();
			node_num  = NODE_RST;
			addr_base = BASE_RST;
			rel_ticks = TICKS_RST;
			for (int i = 0; i < CHANNELS; i++) begin
				last_level[i]  = 1'b0;
				rel_timer[i]   = '0;
				rel_pending[i] = 1'b0;
			end
			errors = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_NODE:  node_num = data;
				CFG_BASE:  addr_base = data;
				CFG_TICKS: rel_ticks = data[TICK_W-1:0];
				default: ;
			endcase
		endfunction

		function void push_event(logic [KIND_W-1:0] kind, int ch);
			sensor_event_t ev;
			ev.kind = kind;
			ev.node = node_num;
			ev.addr = addr_base + ADDR_W'(ch);
			due_events.push_back(ev);
		endfunction

		// Applies one accepted input word to the channel state.
		function void note_word(item_t w);
			int ch;
			ch = int'(w.channel);
			if (w.req_type == REQ_TICK) begin
				for (int i = 0; i < CHANNELS; i++)
					if (rel_pending[i] && rel_timer[i] != 0)
						rel_timer[i] = rel_timer[i] - 1'b1;
				return;
			end
			if (ch >= CHANNELS)
				return;
			if (w.req_type == REQ_POLL) begin
				// An expired delay is cleared even when the event is dropped.
				if (rel_pending[ch] && rel_timer[ch] == 0) begin
					rel_pending[ch] = 1'b0;
					if (w.queue_ready)
						push_event(EV_OFF, ch);
				end
				return;
			end
			if (w.req_type != REQ_SAMPLE)
				return;
			if (!w.start_of_day && w.level == last_level[ch])
				return;
			last_level[ch] = w.level;
			if (!w.start_of_day) begin
				if (!w.level) begin
					rel_timer[ch]   = rel_ticks;
					rel_pending[ch] = 1'b1;
					return;
				end
				// Back to occupied while the delay runs: cancel it quietly.
				if (rel_pending[ch]) begin
					rel_timer[ch]   = rel_ticks;
					rel_pending[ch] = 1'b0;
					return;
				end
			end else if (!w.level) begin
				return;
			end
			// A full queue drops the event and flips the level so the change is seen again.
			if (!w.queue_ready) begin
				last_level[ch] = ~last_level[ch];
				return;
			end
			push_event(w.start_of_day ? EV_SOD_ON : EV_ON, ch);
		endfunction

		function void check_event(sensor_event_t got);
			sensor_event_t exp;
			if (due_events.size() == 0) begin
				$error("unexpected event word: kind %0d, node %0h, address %0h",
					got.kind, got.node, got.addr);
				errors++;
				return;
			end
			exp = due_events.pop_front();
			if (got.kind != exp.kind) begin
				$error("event_kind mismatch: expected %0d, actual %0d", exp.kind, got.kind);
				errors++;
			end
			if (got.node != exp.node) begin
				$error("event_node mismatch: expected %0h, actual %0h", exp.node, got.node);
				errors++;
			end
			if (got.addr != exp.addr) begin
				$error("event_address mismatch: expected %0h, actual %0h", exp.addr, got.addr);
				errors++;
			end
		endfunction

		function int outstanding();
			return due_events.size();
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	osod_in_if  in_if ();
	osod_out_if out_if ();

	occupancy_sensor_off_delay i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.in_ch     (in_if),
		.out_ch    (out_if)
	);

	sensor_event_scoreboard sb = new();

	int            items_sent = 0;
	int            burst_left = 0;
	int            hold_requests = 0;
	int            idle_cycles = 0;
	item_t         mon_word;
	sensor_event_t mon_event;

	// Clock.
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Watch both channels, feed the scoreboard and catch a hung block.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_if.valid && in_if.ready) begin
				mon_word.req_type     = in_if.req_type;
				mon_word.channel      = in_if.channel;
				mon_word.level        = in_if.level;
				mon_word.start_of_day = in_if.start_of_day;
				mon_word.queue_ready  = in_if.queue_ready;
				sb.note_word(mon_word);
			end
			if (out_if.valid && out_if.ready) begin
				mon_event.kind = out_if.event_kind;
				mon_event.node = out_if.event_node;
				mon_event.addr = out_if.event_address;
				sb.check_event(mon_event);
			end
			if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("occupancy_sensor_off_delay test failed");
				$finish;
			end
		end
	end

	// Result side: segments of steady, random or mostly stalled ready, plus long hold-offs.
	initial begin
		int holds_served;
		int mode;
		int seg;
		holds_served = 0;
		out_if.ready = 1'b0;
		forever begin
			if (hold_requests > holds_served) begin
				out_if.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				holds_served++;
			end else begin
				mode = $urandom_range(0, 2);
				seg  = $urandom_range(1, 40);
				repeat (seg) begin
					case (mode)
						0: out_if.ready <= 1'b1;
						1: out_if.ready <= 1'($urandom_range(0, 1));
						default: out_if.ready <= ($urandom_range(0, 3) == 0);
					endcase
					@(posedge clk);
				end
			end
		end
	end

	function automatic logic rand_ready();
		return ($urandom_range(0, 3) != 0);
	endfunction

	function automatic logic [REQ_W-1:0] REQ_TYPE_RAND();
		case ($urandom_range(0, 2))
			0: return REQ_SAMPLE;
			1: return REQ_TICK;
			default: return REQ_POLL;
		endcase
	endfunction

	// Offers one word, with random bursts and gaps, and returns once it is taken.
	task automatic send_req(logic [REQ_W-1:0] req, logic [CHAN_W-1:0] ch, logic lvl,
		logic sod, logic qr);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 30);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_if.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_if.valid        <= 1'b1;
		in_if.req_type     <= req;
		in_if.channel      <= ch;
		in_if.level        <= lvl;
		in_if.start_of_day <= sod;
		in_if.queue_ready  <= qr;
		do @(posedge clk); while (!in_if.ready);
		items_sent++;
	endtask

	task automatic send_noise();
		send_req(REQ_TYPE_RAND(), 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
			($urandom_range(0, 7) == 0), rand_ready());
	endtask

	// Occupied, free, count down the delay and poll for the sensor-off event.
	task automatic release_cycle(bit full);
		logic [CHAN_W-1:0] ch;
		int nt;
		ch = CHAN_W'($urandom_range(0, 7));
		send_req(REQ_SAMPLE, ch, 1'b1, 1'b0, rand_ready());
		send_req(REQ_SAMPLE, ch, 1'b0, 1'b0, rand_ready());
		if (full)
			nt = int'(sb.rel_ticks) + $urandom_range(0, 1);
		else if (sb.rel_ticks <= 8)
			nt = int'(sb.rel_ticks) - 1 + $urandom_range(0, 2);
		else
			nt = $urandom_range(0, 6);
		repeat (nt) begin
			if ($urandom_range(0, 4) == 0)
				send_noise();
			send_req(REQ_TICK, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
		end
		send_req(REQ_POLL, ch, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
			rand_ready());
		if ($urandom_range(0, 2) == 0)
			send_req(REQ_POLL, ch, 1'b0, 1'b0, 1'b1);
	endtask

	// Random part of a phase, mostly complete release sequences.
	task automatic run_random(int n);
		int target;
		int sel;
		logic [CHAN_W-1:0] ch;
		target = items_sent + n;
		release_cycle(1'b1);
		while (items_sent < target) begin
			sel = $urandom_range(0, 9);
			ch  = CHAN_W'($urandom_range(0, 7));
			if (sel < 4) begin
				release_cycle(1'b0);
			end else if (sel < 5) begin
				send_req(REQ_SAMPLE, ch, 1'b0, 1'b0, rand_ready());
				if ($urandom_range(0, 1) == 1)
					send_req(REQ_TICK, ch, 1'b0, 1'b0, 1'b1);
				send_req(REQ_SAMPLE, ch, 1'b1, 1'b0, rand_ready());
			end else if (sel < 6) begin
				send_req(REQ_SAMPLE, ch, 1'($urandom_range(0, 1)), 1'b1, rand_ready());
			end else begin
				send_noise();
			end
		end
	endtask

	// Stop offering words and wait until the block has nothing left in flight.
	task automatic drain_block();
		in_if.valid <= 1'b0;
		burst_left = 0;
		while (sb.outstanding() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= data;
		sb.write_reg(idx, data);
		@(posedge clk);
	endtask

	task automatic configure(logic [NODE_W-1:0] node, logic [ADDR_W-1:0] base,
		logic [TICK_W-1:0] ticks);
		write_reg(CFG_NODE, node);
		write_reg(CFG_BASE, base);
		write_reg(CFG_TICKS, CFG_DATA_W'(ticks));
		cfg_we <= 1'b0;
	endtask

	// Main sequence: reset, directed cases, then random phases under several settings.
	initial begin
		arst_n             = 1'b0;
		cfg_we             = 1'b0;
		cfg_idx            = '0;
		cfg_wdata          = '0;
		in_if.valid        = 1'b0;
		in_if.req_type     = REQ_SAMPLE;
		in_if.channel      = '0;
		in_if.level        = 1'b0;
		in_if.start_of_day = 1'b0;
		in_if.queue_ready  = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings first.
		run_random(FIRST_ITEMS);
		drain_block();

		// Directed cases at the top of the address range, where the address wraps.
		configure(16'hFFFF, 16'hFFFF, 8'd2);
		send_req(REQ_SAMPLE, 3'd0, 1'b1, 1'b0, 1'b1);
		send_req(REQ_SAMPLE, 3'd0, 1'b1, 1'b0, 1'b1);
		send_req(REQ_SAMPLE, 3'd0, 1'b0, 1'b0, 1'b1);
		send_req(REQ_SAMPLE, 3'd0, 1'b1, 1'b0, 1'b1);
		send_req(REQ_SAMPLE, 3'd7, 1'b1, 1'b0, 1'b0);
		send_req(REQ_SAMPLE, 3'd7, 1'b1, 1'b0, 1'b1);
		send_req(REQ_SAMPLE, 3'd7, 1'b0, 1'b0, 1'b1);
		send_req(REQ_POLL, 3'd7, 1'b0, 1'b0, 1'b1);
		send_req(REQ_TICK, 3'd7, 1'b1, 1'b1, 1'b0);
		send_req(REQ_TICK, 3'd0, 1'b0, 1'b0, 1'b1);
		send_req(REQ_TICK, 3'd3, 1'b1, 1'b0, 1'b1);
		send_req(REQ_POLL, 3'd7, 1'b1, 1'b1, 1'b1);
		send_req(REQ_POLL, 3'd7, 1'b0, 1'b0, 1'b1);
		send_req(REQ_SAMPLE, 3'd3, 1'b1, 1'b1, 1'b1);
		send_req(REQ_SAMPLE, 3'd3, 1'b0, 1'b1, 1'b1);
		send_req(REQ_SAMPLE, 3'd4, 1'b1, 1'b1, 1'b0);
		send_req(REQ_SAMPLE, 3'd0, 1'b0, 1'b0, 1'b1);
		send_req(REQ_TICK, 3'd0, 1'b0, 1'b0, 1'b0);
		send_req(REQ_TICK, 3'd0, 1'b0, 1'b0, 1'b0);
		send_req(REQ_POLL, 3'd0, 1'b0, 1'b0, 1'b0);
		send_req(REQ_POLL, 3'd0, 1'b0, 1'b0, 1'b1);
		drain_block();

		// Random phases; the longest delay phase also carries a long result-side hold-off.
		for (int p = 1; p <= 6; p++) begin
			case (p)
				1: configure(16'($urandom), 16'h0000, 8'd1);
				2: configure(16'h0000, 16'($urandom), 8'd255);
				3: configure(16'hFFFF, 16'hFFF9, 8'd3);
				4: configure(16'($urandom), 16'($urandom), 8'($urandom_range(1, 6)));
				5: configure(16'($urandom), 16'($urandom), 8'd2);
				default: configure(16'($urandom), 16'($urandom), 8'($urandom_range(1, 8)));
			endcase
			if (p == 2)
				hold_requests++;
			run_random(PHASE_ITEMS);
			drain_block();
		end

		repeat (10) @(posedge clk);
		if (sb.errors == 0 && sb.outstanding() == 0) begin
			$display("occupancy_sensor_off_delay test passed");
		end else begin
			$display("occupancy_sensor_off_delay test failed");
		end
		$finish;
	end

endmodule

@@ occupancy_sensor_off_delay.f @@
sv/osod_pkg.sv
sv/osod_ifs.sv
sv/osod_decide.sv
sv/osod_bank.sv
sv/osod_out_stage.sv
sv/occupancy_sensor_off_delay.sv
test/tb.sv
